// ===== hw/rtl/gmps_pkg.sv =====
// Package for the grid maximum path sum core.
// Holds the field widths, the result word type and the register index codes.
// Used by every module of the block.
`timescale 1ns / 1ps

package gmps_pkg;

   localparam int VALUE_W = 16;
   localparam int SUM_W   = 24;
   localparam int SIZE_W  = 8;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   // Register indexes on the configuration port.
   localparam logic REG_MATRIX_SIZE = 1'b0;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic signed [SUM_W-1:0]   sum_type;

   // One result word as it leaves the core.
   typedef struct packed {
      sum_type cell_sum;
      logic    is_final;
   } result_type;

endpackage

// ===== hw/rtl/grid_max_path_sum_core.sv =====
// Top level of the grid maximum path sum core.
// Uses gmps_pkg, gmps_cell (row buffer chain) and gmps_out_buf.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_cell_value
//   rsp     | out       | rsp_valid, rsp_ready, rsp_cell_sum, rsp_is_final
//   csr     | in/out    | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// Each word's sum is formed from the head of the cell chain, the left and
// diagonal registers, and lands in the output buffer at the next edge, so a
// word can be accepted every cycle while the output buffer has room. The buffer
// sets req_ready; a stalled rsp side fills its two entries after two words.
// Reset is synchronous and needs no clearing pass; the row buffer is read only
// after the current matrix has written it. A write of matrix_size restarts it.
`timescale 1ns / 1ps

module grid_max_path_sum_core #(
   parameter int MAX_SIZE = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [15:0]             req_cell_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [23:0]             rsp_cell_sum,
   output logic                           rsp_is_final,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gmps_pkg::ADDR_W-1:0]    paddr,
   input  logic [gmps_pkg::DATA_W-1:0]    pwdata,
   output logic [gmps_pkg::DATA_W-1:0]    prdata,
   output logic                           pready
);
   import gmps_pkg::*;

   localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int NW    = $clog2(MAX_SIZE + 1) + 1;

   logic [SIZE_W-1:0] size_ff;
   logic [SIZE_W-1:0] size_in;
   logic [IDX_W-1:0]  row_ff;
   logic [IDX_W-1:0]  row_in;
   logic [IDX_W-1:0]  col_ff;
   logic [IDX_W-1:0]  col_in;
   sum_type           left_ff;
   sum_type           left_in;
   sum_type           diag_ff;
   sum_type           diag_in;

   logic              cfg_write;
   logic              accept;
   logic [NW-1:0]     n_used;
   logic [NW-1:0]     last_idx;
   logic              row_last;
   logic              col_last;
   sum_type           up_sum;
   sum_type           left_sum;
   sum_type           diag_sum;
   sum_type           best_ul;
   sum_type           best;
   sum_type           new_sum;
   result_type        result;
   result_type        out_word;
   logic              has_room;

   sum_type           chain [MAX_SIZE];

   // Configuration port: one register, always ready.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE);
   assign prdata    = (paddr[2] == REG_MATRIX_SIZE) ?
                      {{(DATA_W-SIZE_W){1'b0}}, size_ff} : '0;
   assign size_in   = cfg_write ? pwdata[SIZE_W-1:0] : size_ff;

   // Matrix size in use: zero counts as one, the top is clamped to MAX_SIZE.
   always_comb begin
      if (size_ff == '0) begin
         n_used = NW'(1);
      end else if (32'(size_ff) > 32'(MAX_SIZE)) begin
         n_used = NW'(MAX_SIZE);
      end else begin
         n_used = NW'(size_ff);
      end
   end
   assign last_idx = n_used - NW'(1);
   assign row_last = (NW'(row_ff) == last_idx);
   assign col_last = (NW'(col_ff) == last_idx);

   assign accept    = req_valid && req_ready;
   assign req_ready = has_room;

   // Neighbor selection: anything outside the grid counts as zero.
   assign up_sum   = (row_ff != '0) ? chain[0] : '0;
   assign left_sum = (col_ff != '0) ? left_ff : '0;
   assign diag_sum = ((row_ff != '0) && (col_ff != '0)) ? diag_ff : '0;
   assign best_ul  = (up_sum > left_sum) ? up_sum : left_sum;
   assign best     = (diag_sum > best_ul) ? diag_sum : best_ul;
   assign new_sum  = SUM_W'(req_cell_value) + best;

   assign result.cell_sum = new_sum;
   assign result.is_final = row_last && col_last;

   // Position and neighbor registers.
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      left_in = left_ff;
      diag_in = diag_ff;
      priority if (cfg_write) begin
         row_in  = '0;
         col_in  = '0;
         left_in = '0;
         diag_in = '0;
      end else if (accept) begin
         if (col_last) begin
            col_in  = '0;
            left_in = '0;
            diag_in = '0;
            row_in  = row_last ? '0 : row_ff + IDX_W'(1);
         end else begin
            col_in  = col_ff + IDX_W'(1);
            left_in = new_sum;
            diag_in = up_sum;
         end
      end else begin
         // Idle cycle: position and neighbors hold.
         row_in  = row_ff;
         col_in  = col_ff;
         left_in = left_ff;
         diag_in = diag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(1);
         row_ff  <= '0;
         col_ff  <= '0;
         left_ff <= '0;
         diag_ff <= '0;
      end else begin
         size_ff <= size_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         left_ff <= left_in;
         diag_ff <= diag_in;
      end
   end

   // Row buffer: a chain of cells that shifts toward cell 0 on every word.
   // The new sum enters at the cell that ends the active row, so cell 0 holds
   // the sum of the cell above the next word.
   for (genvar i = 0; i < MAX_SIZE; i++) begin : g_chain
      sum_type upper;
      if (i == MAX_SIZE - 1) begin : g_end
         assign upper = '0;
      end else begin : g_mid
         assign upper = chain[i+1];
      end
      gmps_cell u_cell (
         .clock     (clock),
         .shift     (accept),
         .load_sel  (NW'(i) == last_idx),
         .new_sum   (new_sum),
         .upper_sum (upper),
         .cell_sum  (chain[i])
      );
   end

   // Output buffer toward the rsp side.
   gmps_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .has_room  (has_room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_word)
   );

   assign rsp_cell_sum = out_word.cell_sum;
   assign rsp_is_final = out_word.is_final;

endmodule

// ===== hw/rtl/gmps_cell.sv =====
// One cell of the row buffer chain of the grid maximum path sum core.
// Holds one accumulated sum and hands it to its lower neighbor on every shift.
// Depends on gmps_pkg.
`timescale 1ns / 1ps

module gmps_cell (
   input  logic             clock,
   input  logic             shift,
   input  logic             load_sel,
   input  gmps_pkg::sum_type new_sum,
   input  gmps_pkg::sum_type upper_sum,
   output gmps_pkg::sum_type cell_sum
);
   import gmps_pkg::*;

   sum_type sum_ff;
   sum_type sum_in;

   // The cell at the end of the active row takes the new sum; the others
   // take the value of the neighbor above them in the chain.
   always_comb begin
      sum_in = sum_ff;
      if (shift) begin
         sum_in = load_sel ? new_sum : upper_sum;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign cell_sum = sum_ff;

endmodule

// ===== hw/rtl/gmps_out_buf.sv =====
// Two-entry output buffer of the grid maximum path sum core.
// Lets the core take a new word while a finished result waits downstream.
// Depends on gmps_pkg.
`timescale 1ns / 1ps

module gmps_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  gmps_pkg::result_type push_data,
   output logic                 has_room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output gmps_pkg::result_type out_data
);
   import gmps_pkg::*;

   result_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign has_room  = (count_ff != 2'd2);
   assign out_data  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for grid_max_path_sum_core.
// Streams square matrices through the core under random idling and stalls and predicts every
// path sum in a scoreboard class. Depends on gmps_pkg and the core's RTL only.
`timescale 1ns / 1ps

module testbench;
   import gmps_pkg::*;

   localparam int GRID_MAX    = 128;
   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_TARGET = 1550;
   localparam int SETTLE      = 16;

   // Tracks the grid position and the accumulated sums, and holds the words still owed.
   class path_sum_board;
      sum_type          row_buf [GRID_MAX];
      sum_type          left_acc;
      sum_type          diag_acc;
      int unsigned      row_pos;
      int unsigned      col_pos;
      logic [SIZE_W-1:0] size_reg;
      result_type       owed_words [$];
      int               failures;

      function new();
         foreach (row_buf[i]) row_buf[i] = '0;
         size_reg = SIZE_W'(1);
         failures = 0;
         restart();
      endfunction

      function void restart();
         left_acc = '0;
         diag_acc = '0;
         row_pos  = 0;
         col_pos  = 0;
      endfunction

      // A size write also starts a new matrix.
      function void load_size(logic [SIZE_W-1:0] v);
         size_reg = v;
         restart();
      endfunction

      function int unsigned grid_size();
         if (size_reg == 0) return 1;
         if (size_reg > GRID_MAX) return GRID_MAX;
         return size_reg;
      endfunction

      // Works out the word that an accepted cell causes.
      function void note_cell(value_type v);
         int unsigned n;
         int unsigned col;
         int          up;
         int          left;
         int          diag;
         int          best;
         int          total;
         result_type  word;
         n = grid_size();
         if (row_pos >= n || col_pos >= n) restart();
         col  = col_pos;
         up   = (row_pos > 0) ? int'(row_buf[col]) : 0;
         left = (col > 0) ? int'(left_acc) : 0;
         diag = (row_pos > 0 && col > 0) ? int'(diag_acc) : 0;
         best = (up > left) ? up : left;
         if (diag > best) best = diag;
         total = int'(v) + best;
         word.cell_sum = total[SUM_W-1:0];
         word.is_final = (row_pos == n - 1) && (col == n - 1);
         diag_acc     = up[SUM_W-1:0];
         row_buf[col] = word.cell_sum;
         left_acc     = word.cell_sum;
         col_pos      = col + 1;
         if (col_pos >= n) begin
            col_pos  = 0;
            left_acc = '0;
            diag_acc = '0;
            row_pos++;
            if (row_pos >= n) row_pos = 0;
         end
         owed_words.push_back(word);
      endfunction

      // Compares one accepted word with the oldest one owed.
      function void check_word(sum_type s, logic last);
         result_type want;
         if (owed_words.size() == 0) begin
            $error("unexpected word: cell_sum %0d is_final %0b", s, last);
            failures++;
            return;
         end
         want = owed_words.pop_front();
         if (want.cell_sum !== s) begin
            $error("cell_sum: expected %0d, actual %0d", want.cell_sum, s);
            failures++;
         end
         if (want.is_final !== last) begin
            $error("is_final: expected %0b, actual %0b", want.is_final, last);
            failures++;
         end
      endfunction

      function int pending();
         return owed_words.size();
      endfunction
   endclass

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic signed [15:0]  req_cell_value = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic signed [23:0]  rsp_cell_sum;
   logic                rsp_is_final;
   logic                psel           = 1'b0;
   logic                penable        = 1'b0;
   logic                pwrite         = 1'b0;
   logic [ADDR_W-1:0]   paddr          = '0;
   logic [DATA_W-1:0]   pwdata         = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   path_sum_board board = new();
   int                  cycles     = 0;
   int                  burst_left = 0;
   int                  sent       = 0;

   grid_max_path_sum_core #(
      .MAX_SIZE(GRID_MAX)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cell_value(req_cell_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cell_sum  (rsp_cell_sum),
      .rsp_is_final  (rsp_is_final),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The run ends here if the core stops moving words.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Every accepted cell is predicted, every accepted result word is checked.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_cell(req_cell_value);
      if (!reset && rsp_valid && rsp_ready) board.check_word(rsp_cell_sum, rsp_is_final);
   end

   // The receiver switches between several stall patterns of its own.
   int stall_mode = 0;
   int stall_left = 0;
   int stall_phase = 0;
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(8, 120);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= stall_phase[1];
      endcase
   end

   // Picks a cell value in the style chosen for the current matrix.
   function automatic value_type pick_value(int style);
      case (style)
         0: return value_type'($urandom_range(0, 65535));
         1: begin
            case ($urandom_range(0, 4))
               0: return 16'sh7fff;
               1: return 16'sh8000;
               2: return 16'sh0000;
               3: return 16'sh0001;
               default: return 16'shffff;
            endcase
         end
         2: return value_type'($urandom_range(0, 200)) - 16'sd100;
         3: return value_type'(-$urandom_range(1, 32768));
         default: return value_type'($urandom_range(16384, 32767));
      endcase
   endfunction

   // Sends one word; called at a falling edge and returns at one.
   task automatic push_cell(input value_type v);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_cell_value <= v;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent++;
   endtask

   // Drops req_valid, lets every owed word arrive, then idles before returning.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Writes matrix_size with random upper bits, then reads it back.
   task automatic write_size(input logic [SIZE_W-1:0] v);
      logic [DATA_W-1:0] word;
      word = {(DATA_W-SIZE_W)'($urandom()), v};
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(4 * REG_MATRIX_SIZE);
      pwdata  <= word;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.load_size(v);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[SIZE_W-1:0] !== v) begin
         $error("matrix_size: expected %0d, actual %0d", v, prdata[SIZE_W-1:0]);
         board.failures++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Sends a run of cells of one value style.
   task automatic push_run(input int count, input int style);
      for (int i = 0; i < count; i++) push_cell(pick_value(style));
   endtask

   initial begin
      int size_pick;
      int grid;
      int count;
      int style;
      int r;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The reset size of one makes every cell the last one.
      push_cell(16'sh7fff);
      push_cell(16'sh8000);
      push_cell(16'sh0000);
      wait_idle();

      // A size of zero behaves as one.
      write_size(8'd0);
      push_cell(16'shffff);
      push_cell(16'sh0001);
      wait_idle();

      // A 3x3 matrix of extremes, where negative neighbors lose to the zero border.
      write_size(8'd3);
      push_cell(16'sh8000);
      push_cell(16'sh7fff);
      push_cell(16'shffff);
      push_cell(16'sh7fff);
      push_cell(16'sh8000);
      push_cell(16'sh8000);
      push_cell(16'sh8000);
      push_cell(16'sh8000);
      push_cell(16'sh7fff);
      wait_idle();

      // Rewriting the same size in mid matrix restarts at the top-left cell.
      write_size(8'd2);
      push_cell(16'sh1234);
      push_cell(16'sh8000);
      push_cell(16'sh7fff);
      wait_idle();
      write_size(8'd2);
      push_run(4, 1);
      wait_idle();

      // The largest size, and a size above it that is used as the largest, a few rows each.
      write_size(8'd128);
      push_run(2 * 128 + 10, 0);
      wait_idle();
      write_size(8'($urandom_range(129, 255)));
      push_run(128 + 12, 4);
      wait_idle();
      write_size(8'd255);
      push_run(130, 3);
      wait_idle();

      // Random sizes, mostly small, mostly whole matrices back to back.
      while (sent < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 3) size_pick = 0;
         else if (r < 8) size_pick = 1;
         else if (r < 78) size_pick = $urandom_range(2, 8);
         else size_pick = $urandom_range(9, 24);
         grid  = (size_pick == 0) ? 1 : size_pick;
         count = grid * grid * ((grid > 12) ? 1 : $urandom_range(1, 3));
         if (count > 1 && $urandom_range(0, 4) == 0) count = $urandom_range(1, count - 1);
         r = $urandom_range(0, 9);
         style = (r < 5) ? 0 : (r < 7) ? 1 : (r < 8) ? 2 : (r < 9) ? 3 : 4;
         write_size(8'(size_pick));
         push_run(count, style);
         wait_idle();
      end

      repeat (SETTLE) @(negedge clock);
      if (board.pending() != 0) begin
         $error("%0d result words never arrived", board.pending());
         board.failures++;
      end
      if (board.failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/gmps_pkg.sv
hw/rtl/gmps_cell.sv
hw/rtl/gmps_out_buf.sv
hw/rtl/grid_max_path_sum_core.sv
tb/testbench.sv
